// ===== hdl/spll_pkg.sv =====
// ----------------------------------------------------------------------------
// spll_pkg: shared types and constants of the single-phase grid PLL
// Configuration record, register indexes, fixed-point coefficients, saturation.
// ----------------------------------------------------------------------------
`default_nettype none
package spll_pkg;

  localparam int unsigned CFG_AW = 5;

  // register indexes, one word each at byte address 4*index
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_KP      = 3'd1;
  localparam logic [2:0] REG_KI      = 3'd2;
  localparam logic [2:0] REG_TS      = 3'd3;
  localparam logic [2:0] REG_NOMINAL = 3'd4;
  localparam logic [2:0] REG_DEV     = 3'd5;
  localparam logic [2:0] REG_SOGI_K  = 3'd6;

  typedef struct packed {
    logic        mode;
    logic [15:0] loop_kp;
    logic [15:0] loop_ki;
    logic [31:0] sample_period;
    logic [25:0] nominal_freq;
    logic [25:0] max_deviation;
    logic [15:0] sogi_gain;
  } cfg_t;

  localparam logic        RST_MODE    = 1'b0;
  localparam logic [15:0] RST_KP      = 16'd15360;
  localparam logic [15:0] RST_KI      = 16'd2000;
  localparam logic [31:0] RST_TS      = 32'd429497;
  localparam logic [25:0] RST_NOMINAL = 26'd3276800;
  localparam logic [25:0] RST_DEV     = 26'd327680;
  localparam logic [15:0] RST_SOGI_K  = 16'd23170;

  // odd sine polynomial, Q2.30
  localparam logic [30:0] SIN_A1 = 31'd1686629713;
  localparam logic [30:0] SIN_A3 = 31'd693598668;
  localparam logic [30:0] SIN_A5 = 31'd85569306;
  localparam logic [30:0] SIN_A7 = 31'd5026995;
  localparam logic [30:0] SIN_A9 = 31'd172273;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic signed [32:0] TWO_PI_Q28     = 33'sd1686629713;
  localparam logic signed [32:0] INV_TWO_PI_Q32 = 33'sd683565276;

  // fixed notch biquad, Q2.30
  localparam logic signed [32:0] NOTCH_B0 = 33'sd1487473983;
  localparam logic signed [32:0] NOTCH_B1 = -33'sd2973479947;
  localparam logic signed [32:0] NOTCH_B2 = 33'sd1487473983;
  localparam logic signed [32:0] NOTCH_A1 = -33'sd2103495559;
  localparam logic signed [32:0] NOTCH_A2 = 33'sd1031221648;

  localparam logic [25:0] FREQ_MAX = 26'h3FF_FFFF;

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] res;
    if ((&v[65:31]) || (~|v[65:31])) res = v[31:0];
    else if (v[65]) res = 32'sh8000_0000;
    else res = 32'sh7FFF_FFFF;
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/spll_in_if.sv =====
// ----------------------------------------------------------------------------
// spll_in_if: sample channel
// Valid/ready channel that carries one grid voltage sample per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface spll_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ===== hdl/spll_out_if.sv =====
// ----------------------------------------------------------------------------
// spll_out_if: result channel
// Valid/ready channel that carries phase, frequency, error and signal.
// ----------------------------------------------------------------------------
`default_nettype none
interface spll_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] phase_pu;
  logic        [25:0] freq_est;
  logic signed [31:0] phase_error;
  logic signed [31:0] filtered_signal;
  modport source (output valid, output phase_pu, output freq_est, output phase_error,
                  output filtered_signal, input ready);
  modport sink   (input valid, input phase_pu, input freq_est, input phase_error,
                  input filtered_signal, output ready);
endinterface
`default_nettype wire

// ===== hdl/single_phase_grid_pll.sv =====
// ----------------------------------------------------------------------------
// single_phase_grid_pll: single-phase grid phase-locked loop
// One grid sample in, one phase/frequency result out, via one shared multiplier.
// ----------------------------------------------------------------------------
// Each transferred sample runs a sequence of multiply operations through one
// shared 33 x 33 multiplier. Every operation has an issue phase and then a
// write-back phase, so the multiplier sets the rate. In multiplier mode the
// sequence covers cosine and sine, detector, notch and PI; in SOGI mode it
// covers cosine and sine, the SOGI path and PI. The block takes no new sample
// while it is busy. The result goes to an output register; the next sample
// can be transferred while it still waits, and the sequence only holds at its
// last step if the previous result has not yet been taken. The user must write
// configuration through the APB-style port only while the block is idle; the
// block itself does not enforce this. Sine and cosine use the top
// SINE_TABLE_BITS of the phase.
// ----------------------------------------------------------------------------
`default_nettype none
module single_phase_grid_pll #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  spll_in_if.sink                          in_ch,
  spll_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [spll_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import spll_pkg::*;

  localparam logic [31:0] ANG_MASK =
    ~((32'd1 << (32 - SINE_TABLE_BITS)) - 32'd1);

  // sequencer steps: cosine, sine, detector and notch path, SOGI path, PI and phase
  localparam logic [4:0] OP_C0 = 5'd0,  OP_C1 = 5'd1,  OP_C2 = 5'd2,  OP_C3 = 5'd3;
  localparam logic [4:0] OP_C4 = 5'd4,  OP_C5 = 5'd5,  OP_S0 = 5'd6,  OP_S1 = 5'd7;
  localparam logic [4:0] OP_S2 = 5'd8,  OP_S3 = 5'd9,  OP_S4 = 5'd10, OP_S5 = 5'd11;
  localparam logic [4:0] OP_DET = 5'd12, OP_NB0 = 5'd13, OP_NB1 = 5'd14, OP_NB2 = 5'd15;
  localparam logic [4:0] OP_NA1 = 5'd16, OP_NA2 = 5'd17, OP_PINC = 5'd18, OP_W = 5'd19;
  localparam logic [4:0] OP_KW = 5'd20, OP_T1 = 5'd21, OP_T2 = 5'd22, OP_BT = 5'd23;
  localparam logic [4:0] OP_PC = 5'd24, OP_PS = 5'd25, OP_P = 5'd26, OP_KT = 5'd27;
  localparam logic [4:0] OP_IT = 5'd28, OP_LIM = 5'd29, OP_F = 5'd30, OP_INC = 5'd31;

  cfg_t cfg;

  spll_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  spll_mul u_mul (.clk, .op_a(mul_a), .op_b(mul_b), .prod_r(prod));

  // control
  logic       busy_r, busy_nxt, ph_r, ph_nxt, ov_r, ov_nxt;
  logic [4:0] op_r, op_nxt;

  // loop state
  logic        [31:0] phase_r, phase_nxt;
  logic        [25:0] freq_r, freq_nxt;
  logic signed [31:0] integ_r, integ_nxt;
  logic signed [31:0] dh0_r, dh0_nxt, dh1_r, dh1_nxt, nh0_r, nh0_nxt, nh1_r, nh1_nxt;
  logic signed [31:0] alpha_r, alpha_nxt, beta_r, beta_nxt;

  // working registers
  logic signed [15:0] sample_r;
  logic        [30:0] z2_r, z2_nxt, poly_r, poly_nxt;
  logic signed [31:0] c_r, c_nxt, s_r, s_nxt, det_r, det_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic        [31:0] pinc_r, pinc_nxt, kt_r, kt_nxt;
  logic signed [31:0] w_r, w_nxt, kw_r, kw_nxt, pe_r, pe_nxt, fs_r, fs_nxt;
  logic signed [26:0] p_r, p_nxt;
  logic        [28:0] lim_r, lim_nxt;

  // result register
  logic        [31:0] o_phase_r, o_phase_nxt;
  logic        [25:0] o_freq_r, o_freq_nxt;
  logic signed [31:0] o_pe_r, o_pe_nxt, o_fs_r, o_fs_nxt;

  logic               accept;
  logic        [31:0] ang, ang_t;
  logic        [1:0]  quad;
  logic        [30:0] zf;
  logic signed [32:0] x33;
  logic signed [31:0] e_val;
  logic signed [65:0] p30, p22, p16, p14, p28, p32;
  logic        [30:0] poly_coef;
  logic        [31:0] v_raw, v_cap;
  logic signed [31:0] sin_val;
  logic signed [63:0] y_sum, lim64, it_sum;
  logic signed [65:0] fq, lo, hi, d66;
  logic               last_ok;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy_r;

  assign out_ch.valid           = ov_r;
  assign out_ch.phase_pu        = o_phase_r;
  assign out_ch.freq_est        = o_freq_r;
  assign out_ch.phase_error     = o_pe_r;
  assign out_ch.filtered_signal = o_fs_r;

  // fold the truncated angle into the first quadrant
  assign ang   = phase_r + ((op_r < OP_S0) ? QUARTER_TURN : 32'd0);
  assign ang_t = ang & ANG_MASK;
  assign quad  = ang_t[31:30];
  assign zf    = quad[0] ? (ONE_Q30 - {1'b0, ang_t[29:0]}) : {1'b0, ang_t[29:0]};

  assign x33   = 33'($signed({sample_r, 15'd0}));
  assign e_val = sat32(66'(x33) - 66'(alpha_r));

  assign p30 = prod >>> 30;
  assign p22 = prod >>> 22;
  assign p16 = prod >>> 16;
  assign p14 = prod >>> 14;
  assign p28 = prod >>> 28;
  assign p32 = prod >>> 32;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_C0, OP_S0: begin
        mul_a = 33'({2'b00, zf});
        mul_b = 33'({2'b00, zf});
      end
      OP_C1, OP_S1: begin
        mul_a = 33'({2'b00, z2_r});
        mul_b = 33'({2'b00, SIN_A9});
      end
      OP_C2, OP_C3, OP_C4, OP_S2, OP_S3, OP_S4: begin
        mul_a = 33'({2'b00, z2_r});
        mul_b = 33'({2'b00, poly_r});
      end
      OP_C5, OP_S5: begin
        mul_a = 33'({2'b00, zf});
        mul_b = 33'({2'b00, poly_r});
      end
      OP_DET:  begin mul_a = x33;            mul_b = 33'(c_r);   end
      OP_NB0:  begin mul_a = NOTCH_B0;       mul_b = 33'(det_r); end
      OP_NB1:  begin mul_a = NOTCH_B1;       mul_b = 33'(dh0_r); end
      OP_NB2:  begin mul_a = NOTCH_B2;       mul_b = 33'(dh1_r); end
      OP_NA1:  begin mul_a = NOTCH_A1;       mul_b = 33'(nh0_r); end
      OP_NA2:  begin mul_a = NOTCH_A2;       mul_b = 33'(nh1_r); end
      OP_PINC: begin
        mul_a = 33'({7'd0, freq_r});
        mul_b = {1'b0, cfg.sample_period};
      end
      OP_W:    begin mul_a = {1'b0, pinc_r}; mul_b = TWO_PI_Q28; end
      OP_KW:   begin mul_a = 33'({17'd0, cfg.sogi_gain}); mul_b = 33'(w_r); end
      OP_T1:   begin mul_a = 33'(kw_r);      mul_b = 33'(e_val);   end
      OP_T2:   begin mul_a = 33'(w_r);       mul_b = 33'(beta_r);  end
      OP_BT:   begin mul_a = 33'(w_r);       mul_b = 33'(alpha_r); end
      OP_PC:   begin mul_a = 33'(alpha_r);   mul_b = 33'(c_r);     end
      OP_PS:   begin mul_a = 33'(beta_r);    mul_b = 33'(s_r);     end
      OP_P:    begin mul_a = 33'({17'd0, cfg.loop_kp}); mul_b = 33'(pe_r); end
      OP_KT:   begin
        mul_a = 33'({17'd0, cfg.loop_ki});
        mul_b = {1'b0, cfg.sample_period};
      end
      OP_IT:   begin mul_a = {1'b0, kt_r};   mul_b = 33'(pe_r); end
      OP_LIM:  begin mul_a = TWO_PI_Q28;     mul_b = 33'({7'd0, cfg.max_deviation}); end
      OP_F:    begin mul_a = 33'(p_r) + 33'(integ_r); mul_b = INV_TWO_PI_Q32; end
      OP_INC:  begin
        mul_a = 33'({7'd0, freq_r});
        mul_b = {1'b0, cfg.sample_period};
      end
      default: ;
    endcase
  end

  // write-back helpers
  always_comb begin
    case (op_r)
      OP_C1, OP_S1: poly_coef = SIN_A7;
      OP_C2, OP_S2: poly_coef = SIN_A5;
      OP_C3, OP_S3: poly_coef = SIN_A3;
      default:      poly_coef = SIN_A1;
    endcase
  end

  assign v_raw   = p30[31:0];
  assign v_cap   = (v_raw > {1'b0, ONE_Q30}) ? {1'b0, ONE_Q30} : v_raw;
  assign sin_val = quad[1] ? -$signed(v_cap) : $signed(v_cap);
  assign y_sum   = acc_r - p30[63:0];
  assign lim64   = $signed({35'd0, p28[28:0]});
  assign it_sum  = 64'(integ_r) + p30[63:0];
  assign d66     = 66'(acc_r) - p30;
  assign fq      = 66'($signed({1'b0, cfg.nominal_freq})) + p32;
  assign lo      = 66'($signed({1'b0, cfg.nominal_freq})) -
                   66'($signed({1'b0, cfg.max_deviation}));
  assign hi      = 66'($signed({1'b0, cfg.nominal_freq})) +
                   66'($signed({1'b0, cfg.max_deviation}));
  assign last_ok = !ov_r || out_ch.ready;

  // sequencer
  always_comb begin
    logic signed [65:0] fc;
    logic signed [63:0] ic;
    busy_nxt = busy_r;  ph_nxt = ph_r;  op_nxt = op_r;
    ov_nxt = ov_r && !out_ch.ready;
    phase_nxt = phase_r; freq_nxt = freq_r; integ_nxt = integ_r;
    dh0_nxt = dh0_r; dh1_nxt = dh1_r; nh0_nxt = nh0_r; nh1_nxt = nh1_r;
    alpha_nxt = alpha_r; beta_nxt = beta_r;
    z2_nxt = z2_r; poly_nxt = poly_r; c_nxt = c_r; s_nxt = s_r; det_nxt = det_r;
    acc_nxt = acc_r; pinc_nxt = pinc_r; kt_nxt = kt_r; w_nxt = w_r; kw_nxt = kw_r;
    pe_nxt = pe_r; fs_nxt = fs_r; p_nxt = p_r; lim_nxt = lim_r;
    o_phase_nxt = o_phase_r; o_freq_nxt = o_freq_r; o_pe_nxt = o_pe_r; o_fs_nxt = o_fs_r;
    fc = fq;
    ic = it_sum;

    if (accept) begin
      busy_nxt = 1'b1;
      op_nxt   = OP_C0;
      ph_nxt   = 1'b0;
    end else if (busy_r && !ph_r) begin
      ph_nxt = 1'b1;
    end else if (busy_r && ph_r && (op_r != OP_INC || last_ok)) begin
      ph_nxt = 1'b0;
      op_nxt = op_r + 5'd1;
      case (op_r)
        OP_C0, OP_S0: z2_nxt = p30[30:0];
        OP_C1, OP_C2, OP_C3, OP_C4, OP_S1, OP_S2, OP_S3, OP_S4:
          poly_nxt = poly_coef - p30[30:0];
        OP_C5: c_nxt = sin_val;
        OP_S5: begin
          s_nxt  = sin_val;
          op_nxt = cfg.mode ? OP_PINC : OP_DET;
        end
        OP_DET: det_nxt = p30[31:0];
        OP_NB0: acc_nxt = p30[63:0];
        OP_NB1, OP_NB2: acc_nxt = acc_r + p30[63:0];
        OP_NA1: acc_nxt = y_sum;
        OP_NA2: begin
          // shift the notch histories
          pe_nxt  = sat32(66'(y_sum));
          fs_nxt  = det_r;
          dh1_nxt = dh0_r;
          dh0_nxt = det_r;
          nh1_nxt = nh0_r;
          nh0_nxt = sat32(66'(y_sum));
          op_nxt  = OP_P;
        end
        OP_PINC: pinc_nxt = (|p16[65:32]) ? 32'hFFFF_FFFF : p16[31:0];
        OP_W:    w_nxt    = sat32(p30);
        OP_KW:   kw_nxt   = sat32(p14);
        OP_T1:   acc_nxt  = p30[63:0];
        OP_T2:   acc_nxt  = 64'(sat32(d66));
        OP_BT: begin
          beta_nxt  = sat32(66'(beta_r) + p30);
          alpha_nxt = sat32(66'(alpha_r) + 66'(acc_r));
        end
        OP_PC: acc_nxt = p30[63:0];
        OP_PS: begin
          pe_nxt = sat32(66'(acc_r) + p30);
          fs_nxt = alpha_r;
        end
        OP_P:   p_nxt   = p22[26:0];
        OP_KT:  kt_nxt  = p16[31:0];
        OP_IT:  acc_nxt = it_sum;
        OP_LIM: begin
          ic = acc_r;
          if (ic < -lim64) ic = -lim64;
          if (ic > lim64) ic = lim64;
          integ_nxt = ic[31:0];
          lim_nxt   = p28[28:0];
        end
        OP_F: begin
          if (fc < lo) fc = lo;
          if (fc > hi) fc = hi;
          if (fc < 66'sd0) fc = 66'sd0;
          if (fc > 66'($signed({1'b0, FREQ_MAX}))) fc = 66'($signed({1'b0, FREQ_MAX}));
          freq_nxt = fc[25:0];
        end
        OP_INC: begin
          // advance the phase and hand the result to the output register
          phase_nxt   = phase_r + p16[31:0];
          o_phase_nxt = phase_r + p16[31:0];
          o_freq_nxt  = freq_r;
          o_pe_nxt    = pe_r;
          o_fs_nxt    = fs_r;
          ov_nxt      = 1'b1;
          busy_nxt    = 1'b0;
          op_nxt      = OP_C0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      ph_r    <= 1'b0;
      op_r    <= OP_C0;
      ov_r    <= 1'b0;
      phase_r <= '0;
      freq_r  <= RST_NOMINAL;
      integ_r <= '0;
      dh0_r   <= '0;
      dh1_r   <= '0;
      nh0_r   <= '0;
      nh1_r   <= '0;
      alpha_r <= '0;
      beta_r  <= '0;
    end else begin
      busy_r  <= busy_nxt;
      ph_r    <= ph_nxt;
      op_r    <= op_nxt;
      ov_r    <= ov_nxt;
      phase_r <= phase_nxt;
      freq_r  <= freq_nxt;
      integ_r <= integ_nxt;
      dh0_r   <= dh0_nxt;
      dh1_r   <= dh1_nxt;
      nh0_r   <= nh0_nxt;
      nh1_r   <= nh1_nxt;
      alpha_r <= alpha_nxt;
      beta_r  <= beta_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) sample_r <= in_ch.sample;
    z2_r <= z2_nxt;  poly_r <= poly_nxt;  c_r <= c_nxt;  s_r <= s_nxt;
    det_r <= det_nxt;  acc_r <= acc_nxt;  pinc_r <= pinc_nxt;  kt_r <= kt_nxt;
    w_r <= w_nxt;  kw_r <= kw_nxt;  pe_r <= pe_nxt;  fs_r <= fs_nxt;
    p_r <= p_nxt;  lim_r <= lim_nxt;
    o_phase_r <= o_phase_nxt;  o_freq_r <= o_freq_nxt;
    o_pe_r <= o_pe_nxt;  o_fs_r <= o_fs_nxt;
  end

  // a transfer starts the sequence at its first step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy_r && op_r == OP_C0 && !ph_r))
    else $error("sequence did not start after sample transfer");

  // the result register is only loaded at the last step
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready && !(busy_r && op_r == OP_INC && ph_r)) |=> ov_r)
    else $error("pending result lost");

  // the clamped integrator stays within its limit when the frequency is formed
  a_integ: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && op_r == OP_F) |->
      (integ_r <= $signed({3'b000, lim_r}) && integ_r >= -$signed({3'b000, lim_r})))
    else $error("integrator outside its limit");

endmodule
`default_nettype wire

// ===== hdl/spll_cfg.sv =====
// ----------------------------------------------------------------------------
// spll_cfg: configuration registers
// APB-style write and read of the loop settings.
// ----------------------------------------------------------------------------
`default_nettype none
module spll_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [spll_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output spll_pkg::cfg_t                  cfg
);
  import spll_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] idx;

  assign idx    = paddr[CFG_AW-1:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode          <= RST_MODE;
      cfg_r.loop_kp       <= RST_KP;
      cfg_r.loop_ki       <= RST_KI;
      cfg_r.sample_period <= RST_TS;
      cfg_r.nominal_freq  <= RST_NOMINAL;
      cfg_r.max_deviation <= RST_DEV;
      cfg_r.sogi_gain     <= RST_SOGI_K;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_MODE:    cfg_r.mode          <= pwdata[0];
        REG_KP:      cfg_r.loop_kp       <= pwdata[15:0];
        REG_KI:      cfg_r.loop_ki       <= pwdata[15:0];
        REG_TS:      cfg_r.sample_period <= pwdata;
        REG_NOMINAL: cfg_r.nominal_freq  <= pwdata[25:0];
        REG_DEV:     cfg_r.max_deviation <= pwdata[25:0];
        REG_SOGI_K:  cfg_r.sogi_gain     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:    prdata = {31'd0, cfg_r.mode};
      REG_KP:      prdata = {16'd0, cfg_r.loop_kp};
      REG_KI:      prdata = {16'd0, cfg_r.loop_ki};
      REG_TS:      prdata = cfg_r.sample_period;
      REG_NOMINAL: prdata = {6'd0, cfg_r.nominal_freq};
      REG_DEV:     prdata = {6'd0, cfg_r.max_deviation};
      REG_SOGI_K:  prdata = {16'd0, cfg_r.sogi_gain};
      default:     prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/spll_mul.sv =====
// ----------------------------------------------------------------------------
// spll_mul: shared multiplier
// Signed 33 x 33 multiply with a registered 66-bit product.
// ----------------------------------------------------------------------------
`default_nettype none
module spll_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] op_a,
  input  wire logic signed [32:0] op_b,
  output logic signed [65:0]      prod_r
);
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end
endmodule
`default_nettype wire

// ===== test/tb_single_phase_grid_pll.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_single_phase_grid_pll: self-checking bench for the single-phase grid PLL
// Drives grid samples and APB register writes across several loop settings,
// predicts every result in a scoreboard model and compares it field by field.
// ----------------------------------------------------------------------------
module tb_single_phase_grid_pll;
  import spll_pkg::*;

  localparam int  SINE_BITS  = 10;
  localparam int  CYCLE_CAP  = 1000000;
  localparam int  HOLD_LEN   = 3000;
  localparam int  SETTLE     = 80;
  // one index past the register file; a write there must change nothing
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic        [31:0] phase_pu;
    logic        [25:0] freq_est;
    logic signed [31:0] phase_error;
    logic signed [31:0] filtered_signal;
  } pll_result_t;

  // --------------------------------------------------------------------------
  // Loop model plus the queue of results it has predicted
  // --------------------------------------------------------------------------
  class pll_scoreboard;
    cfg_t          cfg;
    logic [31:0]   phase_acc;
    logic [31:0]   freq_reg;
    longint        integ;
    longint        det_hist[2];
    longint        notch_hist[2];
    longint        alpha, beta;
    pll_result_t   awaited[$];
    int            errors;

    function new();
      cfg = '{RST_MODE, RST_KP, RST_KI, RST_TS, RST_NOMINAL, RST_DEV, RST_SOGI_K};
      phase_acc = '0;
      freq_reg = 32'(RST_NOMINAL);
      integ = 0;
      det_hist = '{0, 0};
      notch_hist = '{0, 0};
      alpha = 0;
      beta = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_MODE:    cfg.mode = val[0];
        REG_KP:      cfg.loop_kp = val[15:0];
        REG_KI:      cfg.loop_ki = val[15:0];
        REG_TS:      cfg.sample_period = val;
        REG_NOMINAL: cfg.nominal_freq = val[25:0];
        REG_DEV:     cfg.max_deviation = val[25:0];
        REG_SOGI_K:  cfg.sogi_gain = val[15:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint sat(longint v);
      return clip(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function longint q30_mul(longint a, longint b);
      return (a * b) >>> 30;
    endfunction

    // polynomial sine on the truncated phase, Q2.30
    function longint sine(logic [31:0] turn);
      logic [31:0]      t;
      longint unsigned  z, z2, r, v;
      t = turn & ~((32'd1 << (32 - SINE_BITS)) - 32'd1);
      z = t[29:0];
      if (t[30]) z = 64'(ONE_Q30) - z;
      z2 = (z * z) >> 30;
      r = 64'(SIN_A9);
      r = 64'(SIN_A7) - ((z2 * r) >> 30);
      r = 64'(SIN_A5) - ((z2 * r) >> 30);
      r = 64'(SIN_A3) - ((z2 * r) >> 30);
      r = 64'(SIN_A1) - ((z2 * r) >> 30);
      v = (z * r) >> 30;
      if (v > 64'(ONE_Q30)) v = 64'(ONE_Q30);
      return t[31] ? -longint'(v) : longint'(v);
    endfunction

    // advance the loop by one sample and queue the result it must produce
    function void note_sample(logic signed [15:0] smp);
      longint x, c, s, err, sig, det, y, w, kw, e, a_old, p, lim, f, lo, hi;
      longint unsigned pinc, kt, inc;
      pll_result_t res;
      x = longint'(smp) * 32768;
      c = sine(phase_acc + QUARTER_TURN);
      s = sine(phase_acc);
      if (!cfg.mode) begin
        det = q30_mul(x, c);
        y = ((longint'(NOTCH_B0) * det) >>> 30) + ((longint'(NOTCH_B1) * det_hist[0]) >>> 30)
          + ((longint'(NOTCH_B2) * det_hist[1]) >>> 30)
          - ((longint'(NOTCH_A1) * notch_hist[0]) >>> 30)
          - ((longint'(NOTCH_A2) * notch_hist[1]) >>> 30);
        det_hist[1] = det_hist[0];
        det_hist[0] = det;
        notch_hist[1] = notch_hist[0];
        notch_hist[0] = sat(y);
        err = notch_hist[0];
        sig = det;
      end else begin
        a_old = alpha;
        pinc = (64'(freq_reg) * 64'(cfg.sample_period)) >> 16;
        if (pinc > 64'hFFFF_FFFF) pinc = 64'hFFFF_FFFF;
        w = sat(longint'((pinc * 64'(TWO_PI_Q28)) >> 30));
        kw = sat((longint'(cfg.sogi_gain) * w) >>> 14);
        e = sat(x - a_old);
        alpha = sat(a_old + sat(q30_mul(kw, e) - q30_mul(w, beta)));
        beta = sat(beta + q30_mul(w, a_old));
        err = sat(q30_mul(alpha, c) + q30_mul(beta, s));
        sig = alpha;
      end
      // PI: proportional term and clamped integrator, both rad/s Q16.16
      p = (longint'(cfg.loop_kp) * err) >>> 22;
      kt = (64'(cfg.loop_ki) * 64'(cfg.sample_period)) >> 16;
      lim = (longint'(TWO_PI_Q28) * longint'(cfg.max_deviation)) >>> 28;
      integ = clip(integ + ((longint'(kt) * err) >>> 30), -lim, lim);
      f = longint'(cfg.nominal_freq) + (((p + integ) * longint'(INV_TWO_PI_Q32)) >>> 32);
      lo = longint'(cfg.nominal_freq) - longint'(cfg.max_deviation);
      hi = longint'(cfg.nominal_freq) + longint'(cfg.max_deviation);
      f = clip(clip(f, lo, hi), 0, longint'(FREQ_MAX));
      freq_reg = 32'(f);
      inc = (64'(freq_reg) * 64'(cfg.sample_period)) >> 16;
      phase_acc = phase_acc + 32'(inc);
      res.phase_pu = phase_acc;
      res.freq_est = freq_reg[25:0];
      res.phase_error = 32'(err);
      res.filtered_signal = 32'(sig);
      awaited.push_back(res);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
    endtask

    task check_result(pll_result_t got);
      pll_result_t want;
      if (awaited.size() == 0) begin
        report("result transfer with nothing outstanding", 1, 0);
        return;
      end
      want = awaited.pop_front();
      if (got.phase_pu !== want.phase_pu)
        report("phase_pu", got.phase_pu, want.phase_pu);
      if (got.freq_est !== want.freq_est)
        report("freq_est", got.freq_est, want.freq_est);
      if (got.phase_error !== want.phase_error)
        report("phase_error", got.phase_error, want.phase_error);
      if (got.filtered_signal !== want.filtered_signal)
        report("filtered_signal", got.filtered_signal, want.filtered_signal);
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  // calm: no idling on either side; hold_go: ask the receiver for one long stall
  bit                  calm = 1'b0;
  bit                  hold_go = 1'b0;
  bit                  hold_taken = 1'b0;
  int                  hold_left = 0;
  int                  cycles = 0;
  real                 grid_turn = 0.0;

  pll_scoreboard       sb;

  spll_in_if  in_ch();
  spll_out_if out_ch();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  single_phase_grid_pll #(.SINE_TABLE_BITS(SINE_BITS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: check every transfer, then pick next cycle's ready. The one
  // long hold-off is counted here so the sender keeps pushing into a full block.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.phase_pu, out_ch.freq_est, out_ch.phase_error,
                        out_ch.filtered_signal});
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 38);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // APB write: setup cycle, then access cycle; the register takes it at the
  // edge closing the access phase since pready never drops.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'({idx, 2'b00});
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Offer one sample, idling at random first, and hold it until transferred.
  task automatic send_sample(input logic signed [15:0] smp);
    while (!calm && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= smp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(smp);
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle.
  task automatic drain();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random samples: mostly a noisy grid sine near the nominal frequency so the
  // loop gets to lock, the rest full-range noise and rail values.
  task automatic run_samples(input int count);
    int  pick;
    real amp, v, step;
    logic signed [15:0] smp;
    amp = $urandom_range(32767, 2000);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      step = (real'(sb.cfg.nominal_freq) / 65536.0) * (real'(sb.cfg.sample_period) / 4294967296.0);
      step = step * (0.97 + 0.06 * real'($urandom_range(1000)) / 1000.0);
      grid_turn = grid_turn + step;
      grid_turn = grid_turn - $floor(grid_turn);
      if ($urandom_range(199) == 0) amp = $urandom_range(32767, 2000);
      if (pick < 72) begin
        v = amp * $sin(6.283185307179586 * grid_turn) + real'($urandom_range(600)) - 300.0;
        if (v > 32767.0) v = 32767.0;
        if (v < -32768.0) v = -32768.0;
        smp = 16'($rtoi(v));
      end else if (pick < 92) begin
        smp = 16'($urandom);
      end else begin
        smp = pick[0] ? 16'sh7FFF : 16'sh8000;
      end
      send_sample(smp);
    end
  endtask

  task automatic run_directed();
    logic signed [15:0] edge_vals[9];
    edge_vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
                  16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh8000};
    foreach (edge_vals[i]) send_sample(edge_vals[i]);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: phases of register settings, each started from an idle block
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset values, multiplier detector: rails and sign patterns
    run_directed();
    drain();

    // SOGI detector, default gains, then a stretch with no idling at all
    write_reg(REG_MODE, 32'd1);
    run_directed();
    run_samples(200);
    calm = 1'b1;
    run_samples(120);
    calm = 1'b0;
    drain();

    // every register at its top; the write past the file must be ignored
    write_reg(REG_KP, 32'hFFFF);
    write_reg(REG_KI, 32'hFFFF);
    write_reg(REG_TS, 32'hFFFF_FFFF);
    write_reg(REG_NOMINAL, 32'h03FF_FFFF);
    write_reg(REG_DEV, 32'h03FF_FFFF);
    write_reg(REG_SOGI_K, 32'hFFFF);
    write_reg(REG_UNUSED, 32'h0000_0000);
    run_directed();
    run_samples(150);
    drain();

    // zero sample period: phase frozen, integrator still
    write_reg(REG_TS, 32'd0);
    run_samples(20);
    drain();

    // deviation beyond nominal so the lower bound saturates at 0 Hz; gains at zero
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_KP, 32'd0);
    write_reg(REG_KI, 32'd0);
    write_reg(REG_SOGI_K, 32'd0);
    write_reg(REG_TS, 32'd429497);
    write_reg(REG_NOMINAL, 32'd3276800);
    write_reg(REG_DEV, 32'd5000000);
    run_samples(120);
    drain();

    // smallest period, zero nominal and zero deviation
    write_reg(REG_TS, 32'd1);
    write_reg(REG_NOMINAL, 32'd0);
    write_reg(REG_DEV, 32'd0);
    write_reg(REG_KP, 32'd15360);
    write_reg(REG_KI, 32'd2000);
    run_samples(80);
    drain();

    // 60 Hz grid at 4 kHz, multiplier detector; stall the receiver meanwhile
    write_reg(REG_TS, 32'd1073742);
    write_reg(REG_NOMINAL, 32'd3932160);
    write_reg(REG_DEV, 32'd327680);
    write_reg(REG_SOGI_K, 32'd23170);
    hold_go = 1'b1;
    run_samples(300);
    drain();

    // mode change without clearing state: SOGI picks up from where it stopped
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_KP, 32'd4000);
    run_samples(350);
    drain();

    // back to multiplier mode, random gains over the full 16-bit range
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_KP, 32'($urandom_range(65535)));
    write_reg(REG_KI, 32'($urandom_range(65535)));
    write_reg(REG_SOGI_K, 32'($urandom_range(65535)));
    run_samples(350);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
